### rtl/agd_pkg.sv
// shared types and constants for the accelerometer gesture detector
// used by agd_ctrl, agd_dp, accel_gesture_detector and the testbench; no dependencies
package agd_pkg;

  localparam int SAMPLE_INTERVAL_DEFAULT = 60;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W       = 80;
  localparam int OUT_W      = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_DELTA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_DELTA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_MAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKES_NEEDED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_WINDOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd7;

  // register reset values
  localparam logic [15:0] RST_SHAKE_DELTA   = 16'd1843;
  localparam logic [15:0] RST_TAP_DELTA     = 16'd1229;
  localparam logic [15:0] RST_FLAT_Z        = 16'd2949;
  localparam logic [15:0] RST_LIFT_MAG      = 16'd5120;
  localparam logic [7:0]  RST_SHAKES_NEEDED = 8'd4;
  localparam logic [15:0] RST_SHAKE_WINDOW  = 16'd1200;
  localparam logic [15:0] RST_COOLDOWN      = 16'd1500;
  localparam logic [15:0] RST_DEBOUNCE      = 16'd400;

  localparam logic [15:0] ONE_G = 16'd4096;

  // gesture codes
  localparam logic [2:0] GEST_NONE    = 3'd0;
  localparam logic [2:0] GEST_SHAKE   = 3'd1;
  localparam logic [2:0] GEST_PICKUP  = 3'd2;
  localparam logic [2:0] GEST_PUTDOWN = 3'd3;
  localparam logic [2:0] GEST_TAP     = 3'd4;

  // axis select for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int NUM_AXES   = 3;
  localparam int ROOT_STEPS = 16;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_sel;
    logic       root_step;
    logic       jolt_step;
    logic       decide;
  } cmd_t;

  typedef struct packed {
    logic due;
  } status_t;

  typedef struct packed {
    logic [15:0] peak_jolt;
    logic        moved;
    logic        held;
    logic [2:0]  gesture;
  } result_t;

endpackage

### rtl/agd_ctrl.sv
// sequencer for the gesture detector: accept, square, root, jolt, decide
// depends on agd_pkg
module agd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  agd_pkg::status_t status,
  output agd_pkg::cmd_t    cmd
);
  import agd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQ     = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_JOLT   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       m_tvalid_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.due) begin
            state_next = ST_SQ;
            cnt_next   = '0;
          end
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.sq_sel  = cnt[1:0];
        if (cnt == 4'(NUM_AXES - 1)) begin
          state_next = ST_ROOT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 4'd1;
        if (cnt == 4'(ROOT_STEPS - 1)) begin
          state_next = ST_JOLT;
        end
      end
      ST_JOLT: begin
        cmd.jolt_step = 1'b1;
        state_next    = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold here until the output register can take the word
        if (out_free) begin
          cmd.decide    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_due_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && status.due) |=> (state == ST_SQ && cnt == 4'd0))
    else $error("due sample did not start squaring");

  a_sq_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (cnt < 4'(NUM_AXES)))
    else $error("axis counter out of range");

  a_root_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && cnt == 4'(ROOT_STEPS - 1)) |=> (state == ST_JOLT))
    else $error("root iteration count wrong");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (!m_tvalid || m_tready))
    else $error("result overwritten while waiting");

endmodule

### rtl/agd_dp.sv
// datapath for the gesture detector: config registers, squarer, root unit,
// jolt and gesture state; depends on agd_pkg
module agd_dp #(
  parameter int SAMPLE_INTERVAL_MS = agd_pkg::SAMPLE_INTERVAL_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [agd_pkg::IN_W-1:0]       s_tdata,
  input  logic                           cfg_we,
  input  logic [agd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  agd_pkg::cmd_t                  cmd,
  output agd_pkg::status_t               status,
  output agd_pkg::result_t               result
);
  import agd_pkg::*;

  // configuration
  logic [15:0] shake_delta, tap_delta, flat_z, lift_mag;
  logic [7:0]  shakes_needed;
  logic [15:0] shake_window_ms, cooldown_ms, debounce_ms;

  // persistent state
  logic [31:0] next_due, window_start, last_gesture_time, change_since;
  logic [15:0] last_magnitude, peak_value;
  logic [7:0]  shake_tally;
  logic        held_state, change_pending;

  // per-sample working registers
  logic [31:0] now;
  logic [15:0] ax, ay, az;
  logic [31:0] acc, root, bitv;
  logic [15:0] jolt;
  logic        cooling, win_exp, deb_exp, now_held;

  logic [31:0] in_time;
  logic [15:0] in_x, in_y, in_z;
  assign in_time = s_tdata[31:0];
  assign in_x    = s_tdata[47:32];
  assign in_y    = s_tdata[63:48];
  assign in_z    = s_tdata[79:64];

  assign status.due = !(in_time < next_due);

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (16'd0 - v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      shake_delta     <= RST_SHAKE_DELTA;
      tap_delta       <= RST_TAP_DELTA;
      flat_z          <= RST_FLAT_Z;
      lift_mag        <= RST_LIFT_MAG;
      shakes_needed   <= RST_SHAKES_NEEDED;
      shake_window_ms <= RST_SHAKE_WINDOW;
      cooldown_ms     <= RST_COOLDOWN;
      debounce_ms     <= RST_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAKE_DELTA:   shake_delta     <= cfg_data;
        REG_TAP_DELTA:     tap_delta       <= cfg_data;
        REG_FLAT_Z:        flat_z          <= cfg_data;
        REG_LIFT_MAG:      lift_mag        <= cfg_data;
        REG_SHAKES_NEEDED: shakes_needed   <= cfg_data[7:0];
        REG_SHAKE_WINDOW:  shake_window_ms <= cfg_data;
        REG_COOLDOWN:      cooldown_ms     <= cfg_data;
        REG_DEBOUNCE:      debounce_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared squarer
  logic [15:0] sq_in;
  logic [31:0] sq;
  always_comb begin
    case (cmd.sq_sel)
      AXIS_X:  sq_in = ax;
      AXIS_Y:  sq_in = ay;
      default: sq_in = az;
    endcase
  end
  assign sq = 32'(sq_in) * 32'(sq_in);

  // one root digit per cycle
  logic [31:0] trial;
  logic        take;
  assign trial = root + bitv;
  assign take  = (acc >= trial);

  logic [15:0] mag, jolt_c;
  assign mag    = root[15:0];
  assign jolt_c = (mag > last_magnitude) ? (mag - last_magnitude) : (last_magnitude - mag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now  <= in_time;
      ax   <= abs16(in_x);
      ay   <= abs16(in_y);
      az   <= abs16(in_z);
      acc  <= '0;
      root <= '0;
      bitv <= 32'h4000_0000;
    end else if (cmd.sq_step) begin
      acc <= acc + sq;
    end else if (cmd.root_step) begin
      if (take) begin
        acc  <= acc - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.jolt_step) begin
      jolt     <= jolt_c;
      cooling  <= (now - last_gesture_time) < {16'd0, cooldown_ms};
      win_exp  <= (now - window_start) > {16'd0, shake_window_ms};
      deb_exp  <= (now - change_since) > {16'd0, debounce_ms};
      now_held <= (az < flat_z) || (mag > lift_mag);
    end
  end

  // gesture decision
  logic [7:0]  tally_base, tally_inc, tally_n;
  logic [31:0] ws_n, lgt_n, since_n;
  logic        held_n, pend_n, mv, skip;
  logic [2:0]  g;

  always_comb begin
    tally_base = win_exp ? 8'd0 : shake_tally;
    tally_inc  = (tally_base == 8'hFF) ? 8'hFF : tally_base + 8'd1;
    tally_n    = shake_tally;
    ws_n       = window_start;
    lgt_n      = last_gesture_time;
    since_n    = change_since;
    held_n     = held_state;
    pend_n     = change_pending;
    mv         = 1'b0;
    skip       = 1'b0;
    g          = GEST_NONE;
    if (jolt > shake_delta) begin
      if (win_exp) begin
        ws_n = now;
      end
      tally_n = tally_inc;
      mv      = 1'b1;
      if (tally_inc >= shakes_needed && !cooling) begin
        tally_n = '0;
        lgt_n   = now;
        g       = GEST_SHAKE;
        skip    = 1'b1;
      end
    end
    if (!skip) begin
      if (now_held != held_state) begin
        if (!change_pending) begin
          pend_n  = 1'b1;
          since_n = now;
        end else if (deb_exp) begin
          // a fresh disagreement starts its timer at now, so only an old one expires
          held_n = now_held;
          pend_n = 1'b0;
          mv     = 1'b1;
          if (!cooling) begin
            lgt_n = now;
            g     = now_held ? GEST_PICKUP : GEST_PUTDOWN;
          end
        end
      end else begin
        pend_n = 1'b0;
      end
      if (!held_n && jolt > tap_delta && jolt < shake_delta && !cooling) begin
        lgt_n = now;
        if (g == GEST_NONE) begin
          g = GEST_TAP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_due          <= '0;
      last_magnitude    <= ONE_G;
      peak_value        <= '0;
      shake_tally       <= '0;
      window_start      <= '0;
      last_gesture_time <= '0;
      held_state        <= 1'b0;
      change_pending    <= 1'b0;
      change_since      <= '0;
    end else begin
      if (cmd.load && status.due) begin
        next_due <= in_time + 32'(SAMPLE_INTERVAL_MS);
      end
      if (cmd.jolt_step) begin
        last_magnitude <= mag;
        if (jolt_c > peak_value) begin
          peak_value <= jolt_c;
        end
      end
      if (cmd.decide) begin
        shake_tally       <= tally_n;
        window_start      <= ws_n;
        last_gesture_time <= lgt_n;
        held_state        <= held_n;
        change_pending    <= pend_n;
        change_since      <= since_n;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      result.gesture   <= g;
      result.held      <= held_n;
      result.moved     <= mv;
      result.peak_jolt <= peak_value;
    end
  end

endmodule

### rtl/accel_gesture_detector.sv
// Gesture detector for timestamped 3-axis accelerometer samples in Q3.12 g.
// A sample whose time is below the next due time is accepted and dropped
// and gives no word. A due sample takes the sequencer through an accept
// step, the shared 16x16 squarer once per axis, the digit-per-cycle square
// root unit, a jolt step and a decision step that loads the output register.
// The decision step waits while the previous word is still held in the
// output register. The next sample is taken once the sequencer is back in
// idle, while the previous result may still wait in the output register.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
module accel_gesture_detector #(
  parameter int SAMPLE_INTERVAL_MS = agd_pkg::SAMPLE_INTERVAL_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
  input  logic [agd_pkg::IN_W-1:0]       s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // gesture[2:0], held[3], moved[4], peak_jolt[20:5], zero fill[23:21]
  output logic [agd_pkg::OUT_W-1:0]      m_tdata,
  input  logic                           cfg_we,
  input  logic [agd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import agd_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  agd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  agd_dp #(
    .SAMPLE_INTERVAL_MS (SAMPLE_INTERVAL_MS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign m_tdata = {3'b000, result.peak_jolt, result.moved, result.held, result.gesture};

endmodule

### sim/tb_accel_gesture_detector.sv
// Self-checking testbench for accel_gesture_detector: streams timestamped
// accelerometer words, predicts every result word and checks it on the fly.
// Depends on rtl/agd_pkg.sv and rtl/accel_gesture_detector.sv with its submodules.
module tb_accel_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import agd_pkg::*;

  localparam int SAMPLE_MS       = SAMPLE_INTERVAL_DEFAULT;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 195;

  typedef enum {MOTION_REST, MOTION_HELD, MOTION_SHAKE, MOTION_TAP, MOTION_NOISE} motion_t;

  // predicts the gesture word of each due sample and checks the dut against it
  class gesture_scoreboard;
    logic [15:0] shake_delta, tap_delta, flat_z, lift_mag;
    logic [15:0] shake_window, cooldown, debounce;
    logic [7:0]  shakes_needed;
    logic [31:0] next_due, window_start, last_gesture, change_since;
    logic [15:0] last_mag, peak;
    logic [7:0]  tally;
    logic        held_st, pending_chg;
    result_t     expected_q[$];
    int          errors;

    function new();
      errors = 0;
      shake_delta = RST_SHAKE_DELTA;
      tap_delta = RST_TAP_DELTA;
      flat_z = RST_FLAT_Z;
      lift_mag = RST_LIFT_MAG;
      shakes_needed = RST_SHAKES_NEEDED;
      shake_window = RST_SHAKE_WINDOW;
      cooldown = RST_COOLDOWN;
      debounce = RST_DEBOUNCE;
      next_due = '0;
      last_mag = ONE_G;
      peak = '0;
      tally = '0;
      window_start = '0;
      last_gesture = '0;
      change_since = '0;
      held_st = 1'b0;
      pending_chg = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHAKE_DELTA:   shake_delta = data;
        REG_TAP_DELTA:     tap_delta = data;
        REG_FLAT_Z:        flat_z = data;
        REG_LIFT_MAG:      lift_mag = data;
        REG_SHAKES_NEEDED: shakes_needed = data[7:0];
        REG_SHAKE_WINDOW:  shake_window = data;
        REG_COOLDOWN:      cooldown = data;
        REG_DEBOUNCE:      debounce = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] abs16(logic [15:0] v);
      return v[15] ? 32'd0 - {16'hFFFF, v} : {16'd0, v};
    endfunction

    // bitwise search for the largest root whose square fits
    function logic [15:0] root16(logic [31:0] v);
      logic [15:0] r;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
        logic [15:0] c;
        c = r | (16'd1 << b);
        if ({16'd0, c} * {16'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    // returns 1 when the sample is due and a result word is expected
    function bit note_input(logic [31:0] now, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z);
      logic [31:0] ax, ay, az;
      logic [15:0] mag, jolt;
      logic        cooling, now_held, moved, done;
      logic [2:0]  gest;
      result_t     r;
      if (now < next_due) return 1'b0;
      next_due = now + SAMPLE_MS;
      ax = abs16(x);
      ay = abs16(y);
      az = abs16(z);
      mag = root16(ax * ax + ay * ay + az * az);
      jolt = (mag > last_mag) ? mag - last_mag : last_mag - mag;
      last_mag = mag;
      if (jolt > peak) peak = jolt;
      cooling = (now - last_gesture) < {16'd0, cooldown};
      gest = GEST_NONE;
      moved = 1'b0;
      done = 1'b0;

      if (jolt > shake_delta) begin
        if (now - window_start > {16'd0, shake_window}) begin
          window_start = now;
          tally = '0;
        end
        if (tally != 8'hFF) tally++;
        moved = 1'b1;
        // a shake ends the sample here
        if (tally >= shakes_needed && !cooling) begin
          tally = '0;
          last_gesture = now;
          gest = GEST_SHAKE;
          done = 1'b1;
        end
      end

      if (!done) begin
        now_held = (az < {16'd0, flat_z}) || (mag > lift_mag);
        if (now_held != held_st) begin
          if (!pending_chg) begin
            pending_chg = 1'b1;
            change_since = now;
          end
          if (now - change_since > {16'd0, debounce}) begin
            held_st = now_held;
            pending_chg = 1'b0;
            moved = 1'b1;
            if (!cooling) begin
              last_gesture = now;
              gest = held_st ? GEST_PICKUP : GEST_PUTDOWN;
            end
          end
        end else begin
          // state agrees again, debounce restarts on the next change
          pending_chg = 1'b0;
        end
        if (!held_st && jolt > tap_delta && jolt < shake_delta && !cooling) begin
          last_gesture = now;
          if (gest == GEST_NONE) gest = GEST_TAP;
        end
      end

      r.gesture = gest;
      r.held = held_st;
      r.moved = moved;
      r.peak_jolt = peak;
      expected_q.push_back(r);
      return 1'b1;
    endfunction

    function void match(string what, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      result_t got, want;
      got = result_t'(word[20:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h", $realtime, word);
        return;
      end
      want = expected_q.pop_front();
      match("gesture", want.gesture, got.gesture);
      match("held", want.held, got.held);
      match("moved", want.moved, got.moved);
      match("peak_jolt", want.peak_jolt, got.peak_jolt);
      match("zero fill", 0, word[OUT_W-1:21]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gesture_scoreboard sb = new();
  bit                no_idle = 1'b0;
  logic [31:0]       gen_time = '0;
  motion_t           motion = MOTION_REST;
  int                motion_left = 0;
  int                motion_idx = 0;

  accel_gesture_detector #(.SAMPLE_INTERVAL_MS(SAMPLE_MS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic send_sample(input logic [31:0] t, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             output bit taken);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x, t};
    do @(posedge clk); while (!s_tready);
    taken = sb.note_input(t, x, y, z);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] sd, input logic [15:0] tap,
                              input logic [15:0] flat, input logic [15:0] lift,
                              input logic [15:0] needed, input logic [15:0] win,
                              input logic [15:0] cool, input logic [15:0] deb);
    write_reg(REG_SHAKE_DELTA, sd);
    write_reg(REG_TAP_DELTA, tap);
    write_reg(REG_FLAT_Z, flat);
    write_reg(REG_LIFT_MAG, lift);
    write_reg(REG_SHAKES_NEEDED, needed);
    write_reg(REG_SHAKE_WINDOW, win);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_DEBOUNCE, deb);
    cfg_we <= 1'b0;
  endtask

  task automatic program_typical(input logic [7:0] needed);
    logic [15:0] sd;
    sd = 16'($urandom_range(600, 4000));
    program_regs(sd, 16'($urandom_range(100, sd)), 16'($urandom_range(1000, 4000)),
                 16'($urandom_range(4200, 9000)), {8'($urandom_range(0, 255)), needed},
                 16'($urandom_range(200, 2500)), 16'($urandom_range(0, 2500)),
                 16'($urandom_range(0, 700)));
  endtask

  // wait for every expected word, then let a dropped word clear the pipe
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic next_sample(output logic [31:0] t, output logic [15:0] x,
                             output logic [15:0] y, output logic [15:0] z);
    int          r, d, sgn;
    logic [32:0] sum;
    r = $urandom_range(0, 99);
    if (r < 75) d = $urandom_range(60, 110);
    else if (r < 87) d = $urandom_range(0, 59);
    else if (r < 95) d = $urandom_range(111, 2500);
    else d = $urandom_range(0, 32'h3FFF_FFFF);
    sum = {1'b0, gen_time} + 33'(d);
    // a wrap that leaves next due far above would make every later sample not due
    if (sum[32] && sum[31:0] < sb.next_due && sb.next_due[31])
      t = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else
      t = sum[31:0];
    gen_time = t;

    if (motion_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 25) motion = MOTION_REST;
      else if (r < 50) motion = MOTION_HELD;
      else if (r < 70) motion = MOTION_SHAKE;
      else if (r < 85) motion = MOTION_TAP;
      else motion = MOTION_NOISE;
      motion_left = $urandom_range(3, 24);
      motion_idx = 0;
    end
    motion_left--;
    motion_idx++;
    sgn = $urandom_range(0, 1) ? 1 : -1;

    x = clamp16($urandom_range(0, 400) - 200);
    y = clamp16($urandom_range(0, 400) - 200);
    z = clamp16(sgn * (4096 + $urandom_range(0, 400) - 200));
    case (motion)
      MOTION_HELD: begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          x = clamp16(sgn * $urandom_range(3000, 5000));
          z = clamp16(sgn * $urandom_range(0, (sb.flat_z > 0) ? sb.flat_z - 1 : 0));
        end else if (r < 85) begin
          x = clamp16(int'(sb.lift_mag) + $urandom_range(100, 3000));
        end
      end
      MOTION_SHAKE: begin
        x = '0;
        y = '0;
        if (motion_idx % 2 == 1)
          z = clamp16(sgn * (4096 + int'(sb.shake_delta) + $urandom_range(1, 4000)));
      end
      MOTION_TAP: begin
        x = '0;
        y = '0;
        z = 16'd4096;
        if (motion_idx % 3 == 1) begin
          if (int'(sb.shake_delta) > int'(sb.tap_delta) + 1)
            d = $urandom_range(sb.tap_delta + 1, sb.shake_delta - 1);
          else
            d = $urandom_range(0, 3000);
          z = clamp16(4096 + d);
        end
      end
      MOTION_NOISE: begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input int n);
    int          taken_cnt;
    bit          taken;
    logic [31:0] t;
    logic [15:0] x, y, z;
    taken_cnt = 0;
    while (taken_cnt < n) begin
      next_sample(t, x, y, z);
      send_sample(t, x, y, z, taken);
      if (taken) taken_cnt++;
    end
    drain();
  endtask

  // receiver: bursts of ready broken by short and occasional long stalls, always ready when no_idle is set
  initial begin
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (no_idle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (r < 55) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    #15_000_000;
    $display("accel_gesture_detector regression: fail");
    $finish;
  end

  initial begin
    bit taken;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset settings
    send_sample(32'd0, 16'd0, 16'd0, 16'd0, taken);
    send_sample(32'd10, 16'd1, 16'd1, 16'd1, taken);
    send_sample(32'd60, 16'h7FFF, 16'h7FFF, 16'h7FFF, taken);
    send_sample(32'd120, 16'h8000, 16'h8000, 16'h8000, taken);
    send_sample(32'd180, 16'd0, 16'd0, 16'h8000, taken);
    for (int k = 0; k < 5; k++)
      send_sample(32'd2000 + 60 * k, 16'd0, 16'd0, (k % 2) ? 16'd12000 : 16'd4096, taken);
    // held change falls in the cooldown of the shake
    for (int k = 0; k < 6; k++)
      send_sample(32'd2400 + 90 * k, 16'd4096, 16'd0, 16'd0, taken);
    for (int k = 0; k < 6; k++)
      send_sample(32'd5000 + 90 * k, 16'd0, 16'd0, 16'd4096, taken);
    send_sample(32'd7500, 16'd0, 16'd0, 16'd5600, taken);
    send_sample(32'd7560, 16'd0, 16'd0, 16'd4096, taken);
    send_sample(32'hFFFF_FFFF, 16'd100, 16'hFF9C, 16'd4096, taken);
    gen_time = 32'hFFFF_FFFF;
    drain();

    program_typical(8'($urandom_range(1, 6)));
    run_phase(ITEMS_PER_PHASE);

    no_idle = 1'b1;
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    run_phase(ITEMS_PER_PHASE);
    no_idle = 1'b0;

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF);
    run_phase(ITEMS_PER_PHASE);

    // zero shakes needed: any jolt above the threshold outside the cooldown is a shake
    program_typical(8'd0);
    run_phase(ITEMS_PER_PHASE);

    for (int p = 0; p < 3; p++) begin
      program_typical(8'($urandom_range(1, 6)));
      run_phase(ITEMS_PER_PHASE);
    end

    program_regs(RST_SHAKE_DELTA, RST_TAP_DELTA, RST_FLAT_Z, RST_LIFT_MAG,
                 {8'd0, RST_SHAKES_NEEDED}, RST_SHAKE_WINDOW, RST_COOLDOWN, RST_DEBOUNCE);
    run_phase(ITEMS_PER_PHASE);

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("accel_gesture_detector regression: pass");
    else
      $display("accel_gesture_detector regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/agd_pkg.sv
rtl/agd_ctrl.sv
rtl/agd_dp.sv
rtl/accel_gesture_detector.sv
sim/tb_accel_gesture_detector.sv
